// ===== rtl/core/teq_pkg.sv =====
// Shared types and constants of the timed event queue.
`default_nettype none
package teq_pkg;

  // Request codes carried on the func field.
  localparam logic [1:0] FUNC_SCHED = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Events emitted at most per request.
  localparam int unsigned MAX_RESULTS = 16;

  // One queued event as kept in the entry memory.
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] handler;
    logic [2:0]  arg_count;
    logic [63:0] arg_a;
    logic [63:0] arg_b;
    logic [31:0] arg_c;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/teq_mem.sv =====
// Entry memory of the timed event queue: one write port, one registered read port.
`default_nettype none
module teq_mem
  import teq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/timed_event_queue.sv =====
// Top level of the timed event queue: ring buffer control, sorted insert and timed pops.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------------
//   in      | input     | in_valid, in_ready, in_func, in_delay, ... in_arg_c
//   out     | output    | out_valid, out_ready, out_status, ..., out_occupancy, out_last
//
// One request is worked at a time. A schedule reads each queued entry due later than the
// new one and moves it one slot up through the single memory read port. A tick pops the
// due events and a flush pops all events, one after another up to MAX_RESULTS. Reset
// clears the count, head and elapsed time; the memory needs no clearing. A stalled
// output holds the sequencer in place.
`default_nettype none
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_delay,
  input  wire logic [31:0] in_time_step,
  input  wire logic [31:0] in_handler,
  input  wire logic [2:0]  in_arg_count,
  input  wire logic [63:0] in_arg_a,
  input  wire logic [63:0] in_arg_b,
  input  wire logic [31:0] in_arg_c,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_handler,
  output logic [2:0]       out_arg_count,
  output logic [63:0]      out_arg_a,
  output logic [63:0]      out_arg_b,
  output logic [31:0]      out_arg_c,
  output logic [4:0]       out_occupancy,
  output logic             out_last
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RES, S_SRD, S_SCMP, S_TRD, S_TCHK
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     idx_r;
  logic [31:0]       elapsed_r;
  logic [4:0]        n_r;
  logic              flush_r;
  logic [1:0]        res_st_r;
  entry_t            new_r;
  logic              pend_r;
  entry_t            pend_ent_r;
  logic [CW-1:0]     pend_occ_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  entry_t            out_ent_r;
  logic [4:0]        out_occ_r;
  logic              out_last_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  logic              out_free;
  logic              out_load;
  logic              pop_ok;
  logic [32:0]       due_sum;
  logic [32:0]       tick_sum;

  // Ring address: base plus offset, folded once into the depth.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [AW+1:0] s;
    s = (AW+2)'(base) + (AW+2)'(off);
    if (s >= (AW+2)'(QUEUE_DEPTH)) begin
      s = s - (AW+2)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  teq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Saturating due time; an empty queue restarts elapsed time at zero.
  assign due_sum  = {1'b0, in_delay} + ((cnt_r == '0) ? 33'd0 : {1'b0, elapsed_r});
  assign tick_sum = {1'b0, elapsed_r} + {1'b0, in_time_step};

  // The head may leave when present, under the cap, and due (or flushing).
  assign pop_ok = (cnt_r != '0) && (n_r < 5'(MAX_RESULTS)) &&
                  (flush_r || (rd_data.due <= elapsed_r));

  // A new result word enters the output register in this cycle.
  assign out_load = out_free && ((state_r == S_RES) ||
                                 ((state_r == S_TCHK) && (pend_r || !pop_ok)));

  // Memory port steering.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = ring_addr(head_r, idx_r);
    wr_data = new_r;
    case (state_r)
      S_SRD: begin
        rd_en   = (idx_r != '0);
        rd_addr = ring_addr(head_r, idx_r - CW'(1));
        wr_en   = (idx_r == '0);
      end
      S_SCMP: begin
        wr_en = 1'b1;
        if (rd_data.due > new_r.due) begin
          wr_data = rd_data;
        end
      end
      S_TRD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, queue state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      elapsed_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r     <= '0;
            flush_r <= (in_func == FUNC_FLUSH);
            case (in_func)
              FUNC_SCHED: begin
                if (cnt_r == CW'(QUEUE_DEPTH)) begin
                  res_st_r <= ST_FULL;
                  state_r  <= S_RES;
                end else begin
                  if (cnt_r == '0) begin
                    elapsed_r <= '0;
                  end
                  new_r.due       <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
                  new_r.handler   <= in_handler;
                  new_r.arg_count <= in_arg_count;
                  new_r.arg_a     <= in_arg_a;
                  new_r.arg_b     <= in_arg_b;
                  new_r.arg_c     <= in_arg_c;
                  idx_r           <= cnt_r;
                  res_st_r        <= ST_DONE;
                  state_r         <= S_SRD;
                end
              end
              FUNC_TICK: begin
                if (cnt_r != '0) begin
                  elapsed_r <= tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
                end
                state_r <= S_TRD;
              end
              FUNC_FLUSH: begin
                state_r <= S_TRD;
              end
              default: begin
                cnt_r    <= '0;
                res_st_r <= ST_DONE;
                state_r  <= S_RES;
              end
            endcase
          end
        end
        S_RES: begin
          if (out_free) begin
            out_status_r <= res_st_r;
            out_ent_r    <= '0;
            out_occ_r    <= 5'(cnt_r);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SRD: begin
          if (idx_r == '0) begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_RES;
          end else begin
            state_r <= S_SCMP;
          end
        end
        S_SCMP: begin
          // A later entry moves up one slot; otherwise the new event lands here.
          if (rd_data.due > new_r.due) begin
            idx_r   <= idx_r - CW'(1);
            state_r <= S_SRD;
          end else begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_RES;
          end
        end
        S_TRD: begin
          state_r <= S_TCHK;
        end
        S_TCHK: begin
          if (out_free) begin
            // The held event goes out once it is known whether another follows.
            if (pend_r) begin
              out_status_r <= ST_EMIT;
              out_ent_r    <= pend_ent_r;
              out_occ_r    <= 5'(pend_occ_r);
              out_last_r   <= !pop_ok;
            end else if (!pop_ok) begin
              out_status_r <= ST_DONE;
              out_ent_r    <= '0;
              out_occ_r    <= 5'(cnt_r);
              out_last_r   <= 1'b1;
            end
            if (pop_ok) begin
              pend_r     <= 1'b1;
              pend_ent_r <= rd_data;
              pend_occ_r <= cnt_r - CW'(1);
              head_r     <= ring_addr(head_r, CW'(1));
              cnt_r      <= cnt_r - CW'(1);
              n_r        <= n_r + 5'd1;
              state_r    <= S_TRD;
            end else begin
              pend_r  <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_handler   = out_ent_r.handler;
  assign out_arg_count = out_ent_r.arg_count;
  assign out_arg_a     = out_ent_r.arg_a;
  assign out_arg_b     = out_ent_r.arg_b;
  assign out_arg_c     = out_ent_r.arg_c;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

`ifndef SYNTH
  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A held event never survives into idle.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("event held while idle");

  // An accepted request keeps the input closed in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after accept");
`endif

endmodule
`default_nettype wire
